@@ rtl/core/ifr_pkg.sv @@
// shared constants, codes and controller/datapath types of the integer field formatter
package ifr_pkg;

    // field width limit and derived counter sizes
    localparam int MAX_WIDTH = 63;
    localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W     = 9;
    localparam int DIG_N     = 11;
    localparam int DIG_IW    = $clog2(DIG_N);
    localparam int ND_W      = $clog2(DIG_N + 1);

    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [DIG_IW-1:0] t_dig_idx;
    typedef logic [ND_W-1:0]   t_nd;

    // conversion kinds
    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_HEX  = 3'd2;
    localparam logic [2:0] OP_OCT  = 3'd3;
    localparam logic [2:0] OP_CHAR = 3'd4;

    // flag bit positions
    localparam int FL_LEFT  = 0;
    localparam int FL_PLUS  = 1;
    localparam int FL_SPACE = 2;
    localparam int FL_ALT   = 3;
    localparam int FL_ZERO  = 4;

    // ascii codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_X     = 8'h78;

    // reciprocal of ten, exact for every 32-bit value with a shift of 35
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SETUP,
        ST_LEAD,
        ST_PREFIX,
        ST_ZPAD,
        ST_DIGIT,
        ST_TRAIL
    } t_state;

    typedef enum logic [1:0] {
        CS_NONE,
        CS_PAD,
        CS_NP,
        CS_ND
    } t_cnt_sel;

    typedef enum logic [1:0] {
        CHR_SPACE,
        CHR_PRE,
        CHR_ZERO,
        CHR_DIG
    } t_chr_sel;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     conv;
        logic     emit;
        logic     last;
        t_cnt_sel cnt_sel;
        t_chr_sel chr_sel;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic op_bad;
        logic conv_done;
        logic lead_en;
        logic np_nz;
        logic zpad_en;
        logic trail_en;
        logic cnt_one;
        logic slot_free;
    } t_sts;

endpackage

@@ rtl/core/ifr_if.sv @@
// handshake channels for conversion requests and output characters
interface ifr_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [31:0] value;
    logic [4:0] flags;
    logic [5:0] width;

    modport source (output valid, output operation, output value, output flags,
                    output width, input ready);
    modport sink   (input valid, input operation, input value, input flags,
                    input width, output ready);
endinterface

interface ifr_chr_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

@@ rtl/core/ifr_datapath.sv @@
// datapath: request registers, digit extraction, digit buffer, counters, output register
module ifr_datapath (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  ifr_pkg::t_cmd i_cmd,
    output ifr_pkg::t_sts o_sts,
    input  logic [2:0]   i_operation,
    input  logic [31:0]  i_value,
    input  logic [4:0]   i_flags,
    input  logic [5:0]   i_width,
    input  logic         i_out_ready,
    output logic         o_out_valid,
    output logic [7:0]   o_out_char,
    output logic         o_out_last
);
    import ifr_pkg::*;

    logic [2:0]  r_op;
    logic [31:0] r_mag;
    logic        r_left, r_zero;
    t_cnt        r_width;
    logic [7:0]  r_pre [2];
    logic [1:0]  r_np;
    t_nd         r_nd;
    logic [7:0]  r_dig [DIG_N];
    t_cnt        r_cnt;
    logic        r_out_valid;
    logic [7:0]  r_out_char;
    logic        r_out_last;

    logic        f_left, f_plus, f_space, f_alt, f_zero, neg;
    logic [63:0] prod;
    logic [31:0] q10, rem10, n_mag;
    logic [3:0]  dig_val;
    logic [7:0]  dig_chr, out_chr;
    t_cnt        len, pad;
    logic        fire;
    t_cnt        dig_rd;
    logic [1:0]  pre_idx;

    // effective flags of the incoming request
    assign f_left  = i_flags[FL_LEFT];
    assign f_plus  = i_flags[FL_PLUS];
    assign f_space = i_flags[FL_SPACE] & ~i_flags[FL_PLUS];
    assign f_alt   = i_flags[FL_ALT];
    assign f_zero  = i_flags[FL_ZERO] & ~i_flags[FL_LEFT];
    assign neg     = (i_operation == OP_SDEC) && ((i_value & SIGN_BIT) != 32'd0);

    // one digit step: divide by the radix, keep the remainder
    assign prod  = 64'(r_mag) * 64'(RECIP10);
    assign q10   = 32'(prod >> RECIP_SHIFT);
    assign rem10 = r_mag - (q10 << 3) - (q10 << 1);

    always_comb begin
        unique case (r_op)
            OP_HEX: begin
                dig_val = r_mag[3:0];
                n_mag   = r_mag >> 4;
            end
            OP_OCT: begin
                dig_val = {1'b0, r_mag[2:0]};
                n_mag   = r_mag >> 3;
            end
            default: begin
                dig_val = rem10[3:0];
                n_mag   = q10;
            end
        endcase
        if (r_op == OP_CHAR) begin
            dig_chr = r_mag[7:0];
        end else if (dig_val < 4'd10) begin
            dig_chr = CH_ZERO + 8'(dig_val);
        end else begin
            dig_chr = CH_A + 8'(dig_val - 4'd10);
        end
    end

    // field length and padding
    assign len = t_cnt'(r_nd) + t_cnt'(r_np);
    assign pad = (r_width > len) ? (r_width - len) : '0;

    assign fire = i_cmd.emit && (!r_out_valid || i_out_ready);

    // request registers and digit buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_mag   <= neg ? (32'd0 - i_value) : i_value;
            r_left  <= f_left;
            r_zero  <= f_zero;
            r_nd    <= '0;
            if (CMP_W'(i_width) > CMP_W'(MAX_WIDTH)) begin
                r_width <= CNT_W'(MAX_WIDTH);
            end else begin
                r_width <= CNT_W'(i_width);
            end
            r_pre[0] <= CH_ZERO;
            r_pre[1] <= CH_X;
            r_np     <= 2'd0;
            priority if (neg) begin
                r_pre[0] <= CH_MINUS;
                r_np     <= 2'd1;
            end else if (i_operation == OP_SDEC && f_plus) begin
                r_pre[0] <= CH_PLUS;
                r_np     <= 2'd1;
            end else if (i_operation == OP_SDEC && f_space) begin
                r_pre[0] <= CH_SPACE;
                r_np     <= 2'd1;
            end else if (i_operation == OP_HEX && f_alt) begin
                r_np     <= 2'd2;
            end else if (i_operation == OP_OCT && f_alt) begin
                r_np     <= 2'd1;
            end
        end else if (i_cmd.conv) begin
            r_dig[DIG_IW'(r_nd)] <= dig_chr;
            r_nd                 <= r_nd + t_nd'(1);
            r_mag                <= n_mag;
        end
    end

    // phase counter: loaded on phase entry, counts down per item sent
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.cnt_sel)
            CS_PAD:  r_cnt <= pad;
            CS_NP:   r_cnt <= t_cnt'(r_np);
            CS_ND:   r_cnt <= t_cnt'(r_nd);
            CS_NONE: begin
                if (fire) begin
                    r_cnt <= r_cnt - t_cnt'(1);
                end
            end
        endcase
    end

    // character select
    assign dig_rd  = r_cnt - t_cnt'(1);
    assign pre_idx = r_np - r_cnt[1:0];

    always_comb begin
        unique case (i_cmd.chr_sel)
            CHR_SPACE: out_chr = CH_SPACE;
            CHR_PRE:   out_chr = r_pre[pre_idx[0]];
            CHR_ZERO:  out_chr = CH_ZERO;
            CHR_DIG:   out_chr = r_dig[dig_rd[DIG_IW-1:0]];
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_char <= out_chr;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

    // status
    assign o_sts.op_bad    = r_op > OP_CHAR;
    assign o_sts.conv_done = (r_op == OP_CHAR) || (n_mag == 32'd0);
    assign o_sts.lead_en   = !r_left && !r_zero && (pad != '0);
    assign o_sts.np_nz     = r_np != 2'd0;
    assign o_sts.zpad_en   = r_zero && (pad != '0);
    assign o_sts.trail_en  = r_left && (pad != '0);
    assign o_sts.cnt_one   = r_cnt == t_cnt'(1);
    assign o_sts.slot_free = !r_out_valid || i_out_ready;

`ifndef SYNTH
    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_cnt != '0)
        else $error("emit with empty phase counter");
    a_nd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.conv |-> r_nd < t_nd'(DIG_N))
        else $error("digit buffer overflow");
    a_dig_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && i_cmd.chr_sel == CHR_DIG) |-> t_cnt'(r_nd) >= r_cnt)
        else $error("digit read beyond extracted digits");
`endif
endmodule

@@ rtl/core/ifr_ctrl.sv @@
// controller: sequences extraction, setup and the output phases of one request
module ifr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ifr_pkg::t_sts i_sts,
    output ifr_pkg::t_cmd o_cmd
);
    import ifr_pkg::*;

    t_state r_state, n_state;
    logic   step;

    assign step = i_sts.slot_free && i_sts.cnt_one;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CONV;
            end
            ST_CONV: begin
                if (i_sts.op_bad) n_state = ST_IDLE;
                else if (i_sts.conv_done) n_state = ST_SETUP;
            end
            ST_SETUP: begin
                priority if (i_sts.lead_en) n_state = ST_LEAD;
                else if (i_sts.np_nz) n_state = ST_PREFIX;
                else if (i_sts.zpad_en) n_state = ST_ZPAD;
                else n_state = ST_DIGIT;
            end
            ST_LEAD: begin
                if (step) n_state = i_sts.np_nz ? ST_PREFIX : ST_DIGIT;
            end
            ST_PREFIX: begin
                if (step) n_state = i_sts.zpad_en ? ST_ZPAD : ST_DIGIT;
            end
            ST_ZPAD: begin
                if (step) n_state = ST_DIGIT;
            end
            ST_DIGIT: begin
                if (step) n_state = i_sts.trail_en ? ST_TRAIL : ST_IDLE;
            end
            ST_TRAIL: begin
                if (step) n_state = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_in_ready    = r_state == ST_IDLE;
        o_cmd.load    = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.conv    = (r_state == ST_CONV) && !i_sts.op_bad;
        o_cmd.emit    = 1'b0;
        o_cmd.last    = 1'b0;
        o_cmd.chr_sel = CHR_SPACE;
        unique case (r_state)
            ST_LEAD: begin
                o_cmd.emit = 1'b1;
            end
            ST_PREFIX: begin
                o_cmd.emit    = 1'b1;
                o_cmd.chr_sel = CHR_PRE;
            end
            ST_ZPAD: begin
                o_cmd.emit    = 1'b1;
                o_cmd.chr_sel = CHR_ZERO;
            end
            ST_DIGIT: begin
                o_cmd.emit    = 1'b1;
                o_cmd.chr_sel = CHR_DIG;
                o_cmd.last    = i_sts.cnt_one && !i_sts.trail_en;
            end
            ST_TRAIL: begin
                o_cmd.emit = 1'b1;
                o_cmd.last = i_sts.cnt_one;
            end
            default: begin
            end
        endcase
        // counter load on entry to a phase
        o_cmd.cnt_sel = CS_NONE;
        if (n_state != r_state) begin
            unique case (n_state)
                ST_LEAD, ST_ZPAD, ST_TRAIL: o_cmd.cnt_sel = CS_PAD;
                ST_PREFIX:                  o_cmd.cnt_sel = CS_NP;
                ST_DIGIT:                   o_cmd.cnt_sel = CS_ND;
                default:                    o_cmd.cnt_sel = CS_NONE;
            endcase
        end
    end

`ifndef SYNTH
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.last && i_sts.slot_free) |=> r_state == ST_IDLE)
        else $error("controller busy after last item");
`endif
endmodule

@@ rtl/core/integer_field_formatter_core.sv @@
// top level of the integer field formatter: controller, datapath and channel wiring
//
// Formats one printf-style integer or character conversion into ASCII.
// Request channel i_req carries operation, value, flags and width; the
// character channel o_chr returns one character per item with last set on
// the final character of the field. Requests with an unknown operation
// produce no characters.
// After a request is accepted the block extracts one digit per cycle
// (up to 10 digits for decimal, 11 for octal, 8 for hex, 1 for char),
// passes through a setup state, then sends one character per cycle
// while the receiver takes them. The field is as long as the larger of
// the width and the digit, sign and prefix count. A new request is taken as
// soon as the last character of the previous one sits in the output register.
// Reset (synchronous, active low) returns the controller to idle and empties
// the output register. While the receiver stalls the output register holds
// its character and the controller waits.
module integer_field_formatter_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ifr_req_if.sink   i_req,
    ifr_chr_if.source o_chr
);
    import ifr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ifr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ifr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_operation (i_req.operation),
        .i_value     (i_req.value),
        .i_flags     (i_req.flags),
        .i_width     (i_req.width),
        .i_out_ready (o_chr.ready),
        .o_out_valid (o_chr.valid),
        .o_out_char  (o_chr.out_char),
        .o_out_last  (o_chr.last)
    );
endmodule
